FILE: rtl/char_lcd_nibble_line_writer_core_assert.svh
// Assertion macros shared by the character LCD line writer modules.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef CHAR_LCD_NIBBLE_LINE_WRITER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_LINE_WRITER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CLNW_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CLNW_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/clnw_pkg.sv
// Shared types, constants and the init nibble table of the LCD line writer.
// No dependencies.
package clnw_pkg;

    localparam int LINE_WIDTH_DEF = 16;
    localparam int LINE_WIDTH_MAX = 40;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WAIT_W     = 17;
    localparam int NIB_W      = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_BYTE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_INIT_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_INIT_2 = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_WAIT_BYTE   = 16'd200;
    localparam logic [CFG_DATA_W-1:0] RST_WAIT_INIT_1 = 16'd22000;
    localparam logic [CFG_DATA_W-1:0] RST_WAIT_INIT_2 = 16'd5000;

    localparam logic [7:0] CMD_LINE_TOP = 8'h80;
    localparam logic [7:0] CMD_LINE_BOT = 8'hC0;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;

    // Power-up sequence length in nibbles and its index width
    localparam int INIT_LEN   = 12;
    localparam int INIT_IDX_W = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ADDR,
        ST_CHAR,
        ST_PAD
    } t_state;

    typedef enum logic [1:0] {
        SRC_INIT,
        SRC_ADDR,
        SRC_CHAR,
        SRC_BLANK
    } t_src;

    typedef struct packed {
        logic accept;
        logic emit;
        t_src src;
        logic last;
        logic pos_inc;
        logic pos_clr;
    } t_ctl;

    typedef struct packed {
        logic out_free;
        logic half;
        logic init_end;
        logic chr_zero;
        logic pos_zero;
        logic pos_full;
        logic pos_last;
    } t_sts;

    // Three 0x3 nibbles, 0x2, then bytes 0x28, 0x0C, 0x01, 0x06 high nibble first
    function automatic logic [NIB_W-1:0] init_nibble(input logic [INIT_IDX_W-1:0] idx);
        logic [NIB_W-1:0] nib;
        case (idx)
            4'd0, 4'd1, 4'd2: nib = 4'h3;
            4'd3, 4'd4:       nib = 4'h2;
            4'd5:             nib = 4'h8;
            4'd7:             nib = 4'hC;
            4'd9:             nib = 4'h1;
            4'd11:            nib = 4'h6;
            default:          nib = 4'h0;
        endcase
        return nib;
    endfunction

endpackage

FILE: rtl/clnw_datapath.sv
// Datapath of the LCD line writer: wait registers, line position, sequence
// counters, nibble selection and the output register. Depends on clnw_pkg.
`include "char_lcd_nibble_line_writer_core_assert.svh"

module clnw_datapath #(
    parameter int LINE_WIDTH = clnw_pkg::LINE_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [clnw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_line,
    input  logic [7:0]                        i_char,
    input  clnw_pkg::t_ctl                    i_ctl,
    output clnw_pkg::t_sts                    o_sts,
    input  logic                              i_m_ready,
    output logic                              o_m_valid,
    output logic [clnw_pkg::NIB_W-1:0]        o_nibble,
    output logic                              o_rs,
    output logic [clnw_pkg::WAIT_W-1:0]       o_wait,
    output logic                              o_last
);
    import clnw_pkg::*;

    localparam int POS_W = $clog2(LINE_WIDTH + 1);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_WIDTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_WIDTH - 1);

    logic [CFG_DATA_W-1:0] r_wait_byte, r_wait_init_1, r_wait_init_2;
    logic [POS_W-1:0]      r_pos;
    logic                  r_half;
    logic [INIT_IDX_W-1:0] r_init_idx;
    logic                  r_line;
    logic [7:0]            r_char;
    logic                  r_valid;
    logic [NIB_W-1:0]      r_nib;
    logic                  r_rs;
    logic [WAIT_W-1:0]     r_wait;
    logic                  r_last;

    logic [7:0]            n_byte;
    logic [NIB_W-1:0]      n_nib;
    logic                  n_rs;
    logic [WAIT_W-1:0]     n_wait;
    logic [WAIT_W-1:0]     wait_byte_x;

    assign wait_byte_x = {1'b0, r_wait_byte};

    always_comb begin
        case (i_ctl.src)
            SRC_ADDR:  n_byte = r_line ? CMD_LINE_BOT : CMD_LINE_TOP;
            SRC_CHAR:  n_byte = r_char;
            default:   n_byte = CHAR_BLANK;
        endcase
        if (i_ctl.src == SRC_INIT) begin
            n_nib = init_nibble(r_init_idx);
            n_rs  = 1'b0;
            case (r_init_idx)
                4'd0:    n_wait = wait_byte_x + {1'b0, r_wait_init_1};
                4'd1:    n_wait = wait_byte_x + {1'b0, r_wait_init_2};
                4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: n_wait = wait_byte_x;
                default: n_wait = '0;
            endcase
        end else begin
            n_nib  = r_half ? n_byte[3:0] : n_byte[7:4];
            n_rs   = (i_ctl.src != SRC_ADDR);
            n_wait = r_half ? wait_byte_x : '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_byte   <= RST_WAIT_BYTE;
            r_wait_init_1 <= RST_WAIT_INIT_1;
            r_wait_init_2 <= RST_WAIT_INIT_2;
            r_pos         <= '0;
            r_half        <= 1'b0;
            r_init_idx    <= '0;
            r_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WAIT_BYTE:   r_wait_byte   <= i_cfg_data;
                    CFG_WAIT_INIT_1: r_wait_init_1 <= i_cfg_data;
                    CFG_WAIT_INIT_2: r_wait_init_2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_ctl.accept) begin
                r_half     <= 1'b0;
                r_init_idx <= '0;
            end else if (i_ctl.emit) begin
                if (i_ctl.src == SRC_INIT) begin
                    r_init_idx <= r_init_idx + 1'b1;
                end else begin
                    r_half <= ~r_half;
                end
            end
            if (i_ctl.pos_clr) begin
                r_pos <= '0;
            end else if (i_ctl.pos_inc) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_ctl.emit) begin
                r_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_line <= i_line;
            r_char <= i_char;
        end
        if (i_ctl.emit) begin
            r_nib  <= n_nib;
            r_rs   <= n_rs;
            r_wait <= n_wait;
            r_last <= i_ctl.last;
        end
    end

    assign o_sts.out_free = !r_valid || i_m_ready;
    assign o_sts.half     = r_half;
    assign o_sts.init_end = (r_init_idx == INIT_IDX_W'(INIT_LEN - 1));
    assign o_sts.chr_zero = (r_char == 8'h00);
    assign o_sts.pos_zero = (r_pos == '0);
    assign o_sts.pos_full = (r_pos == POS_FULL);
    assign o_sts.pos_last = (r_pos == POS_LAST);

    assign o_m_valid = r_valid;
    assign o_nibble  = r_nib;
    assign o_rs      = r_rs;
    assign o_wait    = r_wait;
    assign o_last    = r_last;

    `CLNW_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_FULL, "line position beyond width")
    `CLNW_ASSERT_IMP(a_init_range, i_clk, i_rst_n, 1'b1, r_init_idx <= INIT_IDX_W'(INIT_LEN), "init index out of range")
    `CLNW_ASSERT_IMP(a_pos_inc_room, i_clk, i_rst_n, i_ctl.pos_inc, !o_sts.pos_full, "position advanced past a full line")

endmodule

FILE: rtl/clnw_ctrl.sv
// Sequencing state machine of the LCD line writer: takes items and steps the
// datapath through init, address, character and padding nibbles. Depends on clnw_pkg.
`include "char_lcd_nibble_line_writer_core_assert.svh"

module clnw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  logic           i_action,
    input  logic           i_char_zero,
    input  clnw_pkg::t_sts i_sts,
    output clnw_pkg::t_ctl o_ctl
);
    import clnw_pkg::*;

    t_state r_state, n_state;
    t_ctl   ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        ctl         = '0;
        ctl.src     = SRC_INIT;
        o_s_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    ctl.accept = 1'b1;
                    if (!i_action) begin
                        ctl.pos_clr = 1'b1;
                        n_state     = ST_INIT;
                    end else if (i_sts.pos_zero) begin
                        n_state = ST_ADDR;
                    end else if (i_char_zero) begin
                        // Terminator after a full line: nothing to send
                        if (i_sts.pos_full) begin
                            ctl.pos_clr = 1'b1;
                        end else begin
                            n_state = ST_PAD;
                        end
                    end else if (!i_sts.pos_full) begin
                        n_state = ST_CHAR;
                    end
                end
            end
            ST_INIT: begin
                ctl.src = SRC_INIT;
                if (i_sts.out_free) begin
                    ctl.emit = 1'b1;
                    if (i_sts.init_end) begin
                        ctl.last = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end
            end
            ST_ADDR: begin
                ctl.src = SRC_ADDR;
                if (i_sts.out_free) begin
                    ctl.emit = 1'b1;
                    if (i_sts.half) begin
                        n_state = i_sts.chr_zero ? ST_PAD : ST_CHAR;
                    end
                end
            end
            ST_CHAR: begin
                ctl.src = SRC_CHAR;
                if (i_sts.out_free) begin
                    ctl.emit = 1'b1;
                    if (i_sts.half) begin
                        ctl.last    = 1'b1;
                        ctl.pos_inc = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                ctl.src = SRC_BLANK;
                if (i_sts.out_free) begin
                    ctl.emit = 1'b1;
                    if (i_sts.half) begin
                        if (i_sts.pos_last) begin
                            ctl.last    = 1'b1;
                            ctl.pos_clr = 1'b1;
                            n_state     = ST_IDLE;
                        end else begin
                            ctl.pos_inc = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctl = ctl;

    `CLNW_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, ctl.emit, i_sts.out_free, "nibble overwrites an untaken word")
    `CLNW_ASSERT_IMP(a_accept_no_emit, i_clk, i_rst_n, ctl.accept, !ctl.emit, "emit while taking an item")
    `CLNW_ASSERT_IMP(a_last_on_low, i_clk, i_rst_n, ctl.emit && ctl.last && (ctl.src != SRC_INIT), i_sts.half, "last flag on a high nibble")
    `CLNW_ASSERT_NXT(a_last_to_idle, i_clk, i_rst_n, ctl.emit && ctl.last, r_state == ST_IDLE, "sequence continues after last nibble")

endmodule

FILE: rtl/char_lcd_nibble_line_writer_core.sv
// Character LCD line writer over a 4-bit bus.
// Slave stream: s_axis_tdata = char_code[7:0]; s_axis_tuser = {line_select, action}
//   (action in bit 0). action 0 runs the 12-nibble power-up sequence and clears
//   the line position; action 1 writes one character of the current line.
// Master stream: one word per enable strobe. m_axis_tdata = {3'b0, wait_after[16:0],
//   nibble[3:0]}, m_axis_tuser = reg_select, m_axis_tlast marks the final word of
//   an item. A character at line start is preceded by the line address command;
//   a zero character pads the line with blanks and restarts it; characters past
//   the line width are dropped without output.
// Timing: an item is taken while idle, then its words leave one per cycle, unless
//   m_axis_tready stalls them, from a single output register: 12 words for init,
//   2 or 4 for a character, up to 2 + 2*LINE_WIDTH words for a terminator.
//   The output register and the state machine step set that pace.
// Stall: while m_axis_tready is low the waiting word holds and the sequence
//   pauses; the next item is taken as soon as the previous one has queued its
//   last word, even if that word has not been taken yet.
// Reset (synchronous, active low): wait registers return to 200/22000/5000 ticks,
//   position to line start, output word dropped. Write the wait registers only
//   while idle, through i_cfg_we/i_cfg_index/i_cfg_data.
module char_lcd_nibble_line_writer_core #(
    parameter int LINE_WIDTH = clnw_pkg::LINE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration writes
    input  logic                            i_cfg_we,
    input  logic [clnw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [clnw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Item stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // char_code[7:0]
    input  logic [1:0]                      s_axis_tuser,  // action, line_select
    // Nibble stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,  // nibble[3:0], wait_after[16:0], zeros
    output logic [0:0]                      m_axis_tuser,  // reg_select
    output logic                            m_axis_tlast
);
    import clnw_pkg::*;

    t_ctl              ctl;
    t_sts              sts;
    logic [NIB_W-1:0]  nibble;
    logic              rs;
    logic [WAIT_W-1:0] wait_after;

    clnw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_action    (s_axis_tuser[0]),
        .i_char_zero (s_axis_tdata == 8'h00),
        .i_sts       (sts),
        .o_ctl       (ctl)
    );

    clnw_datapath #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_line      (s_axis_tuser[1]),
        .i_char      (s_axis_tdata),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_nibble    (nibble),
        .o_rs        (rs),
        .o_wait      (wait_after),
        .o_last      (m_axis_tlast)
    );

    // Pack the word: nibble lowest, then the wait count, zero fill to whole bytes
    assign m_axis_tdata = {3'b000, wait_after, nibble};
    assign m_axis_tuser = rs;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for char_lcd_nibble_line_writer_core: random and directed items
// against an in-bench model of the nibble sequencer. Depends on clnw_pkg and the core.
module testbench;
    import clnw_pkg::*;

    localparam int LINE_WIDTH   = LINE_WIDTH_DEF;
    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_AFTER_WORDS = 150;
    localparam int HOLD_CYCLES  = 400;

    localparam logic ACT_INIT = 1'b0;
    localparam logic ACT_CHAR = 1'b1;
    localparam logic RS_CMD   = 1'b0;
    localparam logic RS_DATA  = 1'b1;
    localparam logic LINE_TOP = 1'b0;
    localparam logic LINE_BOT = 1'b1;

    localparam logic [3:0] WAKE_NIB   = 4'h3;
    localparam logic [3:0] MODE4_NIB  = 4'h2;
    localparam logic [7:0] CMD_FUNC   = 8'h28;
    localparam logic [7:0] CMD_DISP   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR  = 8'h01;
    localparam logic [7:0] CMD_ENTRY  = 8'h06;
    localparam logic [7:0] CHAR_END   = 8'h00;

    typedef struct {
        logic       action;
        logic       line_sel;
        logic [7:0] code;
    } t_lcd_item;

    typedef struct {
        logic [3:0]  nib;
        logic        rs;
        logic [16:0] hold;
        logic        last;
    } t_strobe;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // char_code[7:0]
    logic [1:0]  s_axis_tuser = '0;   // action, line_select
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // nibble[3:0], wait_after[16:0], zeros
    logic [0:0]  m_axis_tuser;        // reg_select
    logic        m_axis_tlast;

    // Model state: wait registers and the current line position
    logic [15:0] wait_byte;
    logic [15:0] wait_init1;
    logic [15:0] wait_init2;
    int          line_pos;

    t_lcd_item   pending_items[$];
    t_strobe     strobe_q[$];
    int          items_queued = 0;
    int          items_taken = 0;
    int          words_seen = 0;
    int          errors = 0;
    int          cycles = 0;
    logic        steady = 1'b0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        hold_off = 1'b0;

    char_lcd_nibble_line_writer_core #(.LINE_WIDTH(LINE_WIDTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL char_lcd_nibble_line_writer_core");
            $finish;
        end
    end

    function automatic void push_strobe(input logic [3:0] nib, input logic rs,
                                        input logic [16:0] hold);
        t_strobe s;
        s.nib  = nib;
        s.rs   = rs;
        s.hold = hold;
        s.last = 1'b0;
        strobe_q.push_back(s);
    endfunction

    // High nibble holds nothing, low nibble holds the per-byte wait
    function automatic void push_byte(input logic [7:0] b, input logic rs);
        push_strobe(b[7:4], rs, 17'd0);
        push_strobe(b[3:0], rs, {1'b0, wait_byte});
    endfunction

    // Expected strobes for one accepted item; advance the line position
    function automatic void predict_strobes(input t_lcd_item it);
        int q_mark;
        q_mark = strobe_q.size();
        if (it.action == ACT_INIT) begin
            push_strobe(WAKE_NIB, RS_CMD, {1'b0, wait_byte} + {1'b0, wait_init1});
            push_strobe(WAKE_NIB, RS_CMD, {1'b0, wait_byte} + {1'b0, wait_init2});
            push_strobe(WAKE_NIB, RS_CMD, {1'b0, wait_byte});
            push_strobe(MODE4_NIB, RS_CMD, {1'b0, wait_byte});
            push_byte(CMD_FUNC, RS_CMD);
            push_byte(CMD_DISP, RS_CMD);
            push_byte(CMD_CLEAR, RS_CMD);
            push_byte(CMD_ENTRY, RS_CMD);
            line_pos = 0;
        end else begin
            if (line_pos == 0)
                push_byte(it.line_sel ? CMD_LINE_BOT : CMD_LINE_TOP, RS_CMD);
            if (it.code == CHAR_END) begin
                while (line_pos < LINE_WIDTH) begin
                    push_byte(CHAR_BLANK, RS_DATA);
                    line_pos++;
                end
                line_pos = 0;
            end else if (line_pos < LINE_WIDTH) begin
                push_byte(it.code, RS_DATA);
                line_pos++;
            end
        end
        if (strobe_q.size() > q_mark)
            strobe_q[strobe_q.size()-1].last = 1'b1;
    endfunction

    // Driver: offer queued items, hold a word until it is taken
    always @(posedge i_clk) begin : drive_items
        t_lcd_item cur;
        t_lcd_item nxt;
        logic      took;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            took = s_axis_tvalid && s_axis_tready;
            if (took) begin
                cur.action   = s_axis_tuser[0];
                cur.line_sel = s_axis_tuser[1];
                cur.code     = s_axis_tdata;
                predict_strobes(cur);
                items_taken++;
            end
            if (s_axis_tvalid && !took) begin
                // hold the offered word
            end else if (pending_items.size() != 0 &&
                         (steady || $urandom_range(99) >= 29)) begin
                nxt = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= nxt.code;
                s_axis_tuser  <= {nxt.line_sel, nxt.action};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Hold off the receiver once for a long stretch so the core backs up into its input
    always @(posedge i_clk) begin : hold_ready
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
            hold_off  <= 1'b0;
        end else if (!hold_done && words_seen >= HOLD_AFTER_WORDS) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            hold_off  <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            hold_off  <= (hold_left > 1);
        end
    end

    // Monitor: check each taken word against the oldest expectation
    always @(posedge i_clk) begin : watch_strobes
        t_strobe want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                words_seen++;
                if (strobe_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word tdata=%h tuser=%b tlast=%b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = strobe_q.pop_front();
                    if (m_axis_tdata[3:0] !== want.nib) begin
                        errors++;
                        $display("%0t: nibble expected %h actual %h", $time,
                                 want.nib, m_axis_tdata[3:0]);
                    end
                    if (m_axis_tdata[20:4] !== want.hold) begin
                        errors++;
                        $display("%0t: wait_after expected %0d actual %0d", $time,
                                 want.hold, m_axis_tdata[20:4]);
                    end
                    if (m_axis_tdata[23:21] !== 3'b000) begin
                        errors++;
                        $display("%0t: tdata padding expected 0 actual %b", $time,
                                 m_axis_tdata[23:21]);
                    end
                    if (m_axis_tuser[0] !== want.rs) begin
                        errors++;
                        $display("%0t: reg_select expected %b actual %b", $time,
                                 want.rs, m_axis_tuser[0]);
                    end
                    if (m_axis_tlast !== want.last) begin
                        errors++;
                        $display("%0t: last expected %b actual %b", $time,
                                 want.last, m_axis_tlast);
                    end
                end
            end
            if (hold_off) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 29);
            end
        end
    end

    task automatic add_item(input logic action, input logic line_sel, input logic [7:0] code);
        t_lcd_item it;
        it.action   = action;
        it.line_sel = line_sel;
        it.code     = code;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Wait until every item is taken and every strobe seen, then let the core drain
    task automatic settle();
        do @(posedge i_clk);
        while (items_taken != items_queued || strobe_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_WAIT_BYTE:   wait_byte  = val;
            CFG_WAIT_INIT_1: wait_init1 = val;
            CFG_WAIT_INIT_2: wait_init2 = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_waits(input logic [15:0] wb, input logic [15:0] w1,
                               input logic [15:0] w2);
        write_reg(CFG_WAIT_BYTE, wb);
        write_reg(CFG_WAIT_INIT_1, w1);
        write_reg(CFG_WAIT_INIT_2, w2);
    endtask

    // Mostly whole lines with random content, some inits, some raw noise
    task automatic queue_random(input int n);
        int   cnt;
        int   len;
        int   r;
        logic sel;
        cnt = 0;
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 8) begin
                add_item(ACT_INIT, 1'($urandom_range(1)), 8'($urandom_range(255)));
                cnt++;
            end else if (r < 20) begin
                add_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
                cnt++;
            end else begin
                len = $urandom_range(20);
                sel = 1'($urandom_range(1));
                for (int k = 0; k < len; k++)
                    add_item(ACT_CHAR, (k == 0) ? sel : 1'($urandom_range(1)),
                             8'($urandom_range(255, 1)));
                cnt += (len > LINE_WIDTH) ? LINE_WIDTH : len;
                if ($urandom_range(99) < 85) begin
                    add_item(ACT_CHAR, 1'($urandom_range(1)), CHAR_END);
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        wait_byte  = RST_WAIT_BYTE;
        wait_init1 = RST_WAIT_INIT_1;
        wait_init2 = RST_WAIT_INIT_2;
        line_pos   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: init, full line with extreme codes, overflow, terminators
        add_item(ACT_INIT, LINE_TOP, 8'h00);
        add_item(ACT_CHAR, LINE_TOP, 8'h41);
        add_item(ACT_CHAR, LINE_BOT, 8'hFF);
        add_item(ACT_CHAR, LINE_TOP, 8'h01);
        add_item(ACT_CHAR, LINE_BOT, 8'h80);
        add_item(ACT_CHAR, LINE_TOP, 8'h7F);
        for (int k = 5; k < LINE_WIDTH; k++)
            add_item(ACT_CHAR, k[0], 8'h30 + k[7:0]);
        add_item(ACT_CHAR, LINE_TOP, 8'h55);     // past the line end: dropped
        add_item(ACT_CHAR, LINE_BOT, CHAR_END);  // full line: no output, restart
        add_item(ACT_CHAR, LINE_BOT, CHAR_END);  // empty line: address and all blanks
        add_item(ACT_CHAR, LINE_BOT, 8'h42);
        add_item(ACT_CHAR, LINE_TOP, CHAR_END);  // pad from mid-line
        add_item(ACT_CHAR, LINE_TOP, 8'h43);
        add_item(ACT_INIT, LINE_BOT, 8'hFF);     // init mid-line clears position
        add_item(ACT_CHAR, LINE_TOP, 8'h44);
        queue_random(55);
        settle();

        write_waits(16'd0, 16'd0, 16'd0);
        steady = 1'b1;
        queue_random(60);
        settle();
        steady = 1'b0;

        write_waits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_random(60);
        settle();

        write_waits(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                    16'($urandom_range(65535)));
        queue_random(80);
        settle();

        write_waits(16'd1, 16'hFFFF, 16'd0);
        queue_random(60);
        settle();

        if (errors == 0) begin
            $display("PASS char_lcd_nibble_line_writer_core");
        end else begin
            $display("FAIL char_lcd_nibble_line_writer_core");
        end
        $finish;
    end

endmodule
